// ===== rtl/qsst_pkg.sv =====
// ----------------------------------------------------------------------------
// qsst_pkg
// Shared widths, codes and types of the queue slot stall tracker.
// ----------------------------------------------------------------------------
package qsst_pkg;

  localparam int CYCLE_W     = 32;
  localparam int LAT_W       = 12;
  localparam int COST_W      = 8;
  localparam int STALL_W     = 12;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_REGS    = 5;
  localparam int KIND_W      = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 48;

  localparam logic [STALL_W-1:0] STALL_MAX = '1;

  typedef enum logic {
    REQ_PROBE = 1'b0,
    REQ_ISSUE = 1'b1
  } req_e;

  // control broadcast to every cell of a queue
  typedef struct packed {
    logic               wr;
    logic [CYCLE_W-1:0] cc;
    logic [CYCLE_W-1:0] thr;
    logic [CYCLE_W-1:0] val;
  } slot_ctl_t;

  // data handed from one cell to its right neighbor
  typedef struct packed {
    logic               ge;
    logic               keep;
    logic [CYCLE_W-1:0] ft;
  } cell_link_t;

  // per-queue status towards the top level
  typedef struct packed {
    logic               full;
    logic               stale;
    logic [CYCLE_W-1:0] mn;
  } queue_stat_t;

endpackage

// ===== rtl/queue_slot_stall_tracker.sv =====
// ----------------------------------------------------------------------------
// queue_slot_stall_tracker
// Issue queue slot tracker returning stall cycles and running cycle count.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transaction: tuser holds req_type and
//   queue_kind, tdata holds exec_latency and issue_cost. m_axis returns one
//   result per request: stall count and cycle_now in tdata.
//   The cfg channel writes the slot count of a queue (index 0 valu .. 4 lgkm)
//   and is always ready; write it only while no request is in flight.
//   One request per cycle unless stalled; a result appears in the cycle
//   after acceptance. The per-cycle path is the selected queue row:
//   live-slot compare in every cell, minimum pick, cycle advance, and the
//   sorted insertion where each cell looks at its left neighbor.
//   Reset clears all slots, the running cycle and sets each slot count to 1.
//   When the receiver stalls the result register holds its value and
//   s_axis_tready_o drops until the result is taken.
// ----------------------------------------------------------------------------
module queue_slot_stall_tracker #(
  parameter int MAX_SLOTS  = 16,
  parameter int NUM_QUEUES = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // exec_latency [11:0], issue_cost [19:12], zero [23:20]
  input  logic [qsst_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // req_type [0], queue_kind [3:1]
  input  logic [qsst_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // stall_cnt [11:0], cycle_now [43:12], zero [47:44]
  output logic [qsst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [qsst_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [qsst_pkg::CFG_W-1:0]         cfg_data_i
);
  import qsst_pkg::*;

  localparam int NQ = (NUM_QUEUES < NUM_REGS) ? NUM_QUEUES : NUM_REGS;

  function automatic logic [CYCLE_W-1:0] sat_add(logic [CYCLE_W-1:0] a,
                                                 logic [CYCLE_W-1:0] b);
    logic [CYCLE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CYCLE_W] ? '1 : s[CYCLE_W-1:0];
  endfunction

  logic [CFG_W-1:0]   cfg_slots_q [NUM_REGS];
  logic [CYCLE_W-1:0] cc_q, cc_d;
  logic               out_valid_q, out_valid_d;
  logic [STALL_W-1:0] stall_q, stall_d;
  logic [CYCLE_W-1:0] cyc_q, cyc_d;

  queue_stat_t        qstat [NQ];
  queue_stat_t        st;
  slot_ctl_t          ctl   [NQ];

  logic               in_acc;
  logic               is_issue;
  logic [KIND_W-1:0]  kind;
  logic [LAT_W-1:0]   lat;
  logic [COST_W-1:0]  cost;
  logic               known;
  logic [CYCLE_W-1:0] thr;
  logic [CYCLE_W-1:0] new_ft;
  logic [CYCLE_W-1:0] cc_next;
  logic [CYCLE_W-1:0] diff;

  assign is_issue = (s_axis_tuser_i[0] == REQ_ISSUE);
  assign kind     = s_axis_tuser_i[3:1];
  assign lat      = s_axis_tdata_i[11:0];
  assign cost     = s_axis_tdata_i[19:12];
  assign known    = (32'(kind) < NQ);

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_comb begin
    st = '0;
    for (int q = 0; q < NQ; q++) begin
      if (kind == KIND_W'(q)) begin
        st = qstat[q];
      end
    end
  end

  assign thr     = st.full ? st.mn : cc_q;
  assign new_ft  = sat_add(thr, CYCLE_W'(lat));
  assign cc_next = sat_add(thr, CYCLE_W'(cost));
  assign diff    = st.mn - cc_q;

  for (genvar q = 0; q < NQ; q++) begin : g_queue
    assign ctl[q] = '{wr:  in_acc & is_issue & (kind == KIND_W'(q)),
                      cc:  cc_q,
                      thr: thr,
                      val: new_ft};
    qsst_queue #(
      .MAX_SLOTS (MAX_SLOTS)
    ) u_queue (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .slots_i (cfg_slots_q[q]),
      .ctl_i   (ctl[q]),
      .stat_o  (qstat[q])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    stall_d     = stall_q;
    cyc_d       = cyc_q;
    cc_d        = cc_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      out_valid_d = 1'b1;
      stall_d     = '0;
      cyc_d       = cc_q;
      if (known && st.full && (is_issue || !st.stale)) begin
        stall_d = (diff > CYCLE_W'(STALL_MAX)) ? STALL_MAX : diff[STALL_W-1:0];
      end
      if (known && is_issue) begin
        cc_d  = cc_next;
        cyc_d = cc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q        <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < NUM_REGS; r++) begin
        cfg_slots_q[r] <= CFG_W'(1);
      end
    end else begin
      cc_q        <= cc_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && (32'(cfg_index_i) < NUM_REGS)) begin
        cfg_slots_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stall_q <= stall_d;
    cyc_q   <= cyc_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, cyc_q, stall_q};

endmodule

// ===== rtl/qsst_cell.sv =====
// ----------------------------------------------------------------------------
// qsst_cell
// One slot of a queue row; rows are kept sorted by free time, largest first.
// ----------------------------------------------------------------------------
module qsst_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qsst_pkg::slot_ctl_t  ctl_i,
  input  qsst_pkg::cell_link_t link_i,
  output qsst_pkg::cell_link_t link_o,
  output logic                 keep1_o,
  output logic                 stale_o
);
  import qsst_pkg::*;

  logic               valid_q, valid_d;
  logic [CYCLE_W-1:0] ft_q, ft_d;
  logic               keep2;
  logic               ge;

  assign keep1_o = valid_q & (ft_q > ctl_i.cc);
  assign stale_o = valid_q & ~(ft_q > ctl_i.cc);
  assign keep2   = valid_q & (ft_q > ctl_i.thr);
  assign ge      = keep2 & (ft_q >= ctl_i.val);
  assign link_o  = '{ge: ge, keep: keep2, ft: ft_q};

  always_comb begin
    valid_d = valid_q;
    ft_d    = ft_q;
    if (ctl_i.wr) begin
      if (ge) begin
        valid_d = 1'b1;
      end else if (link_i.ge) begin
        valid_d = 1'b1;
        ft_d    = ctl_i.val;
      end else begin
        valid_d = link_i.keep;
        ft_d    = link_i.ft;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ft_q <= ft_d;
  end

endmodule

// ===== rtl/qsst_queue.sv =====
// ----------------------------------------------------------------------------
// qsst_queue
// Row of slot cells for one issue queue, with fullness and minimum lookup.
// ----------------------------------------------------------------------------
module qsst_queue #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [qsst_pkg::CFG_W-1:0]    slots_i,
  input  qsst_pkg::slot_ctl_t           ctl_i,
  output qsst_pkg::queue_stat_t         stat_o
);
  import qsst_pkg::*;

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  cell_link_t           link   [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] keep1;
  logic [MAX_SLOTS-1:0] stale;
  logic [MAX_SLOTS:0]   keep1_ext;
  logic [IW-1:0]        full_idx;
  logic [CYCLE_W-1:0]   mn;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    cell_link_t link_in;
    if (i == 0) begin : g_head
      assign link_in = '{ge: 1'b1, keep: 1'b0, ft: '0};
    end else begin : g_body
      assign link_in = link[i-1];
    end
    qsst_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_i),
      .link_i  (link_in),
      .link_o  (link[i]),
      .keep1_o (keep1[i]),
      .stale_o (stale[i])
    );
  end

  assign keep1_ext = {1'b0, keep1};

  // clamp configured depth to one through MAX_SLOTS
  always_comb begin
    if (slots_i == '0) begin
      full_idx = '0;
    end else if (32'(slots_i) >= MAX_SLOTS) begin
      full_idx = IW'(MAX_SLOTS - 1);
    end else begin
      full_idx = IW'(slots_i - CFG_W'(1));
    end
  end

  // smallest live free time sits in the last live cell
  always_comb begin
    mn = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (keep1_ext[i] && !keep1_ext[i+1]) begin
        mn = mn | link[i].ft;
      end
    end
  end

  assign stat_o = '{full: keep1[full_idx], stale: |stale, mn: mn};

endmodule

// ===== rtl/qsst_checker.sv =====
// ----------------------------------------------------------------------------
// qsst_checker
// Port-level checks of the queue slot stall tracker, bound to the top level.
// ----------------------------------------------------------------------------
module qsst_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [qsst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import qsst_pkg::*;

  // empty result register always takes a request
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("tready low with empty result register");

  // every accepted transaction shows a result next cycle
  a_one_cycle_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> m_axis_tvalid_o)
    else $error("no result one cycle after accepted transaction");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

endmodule

bind queue_slot_stall_tracker qsst_checker u_qsst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
